// ===== hw/rtl/key_matrix_debounce_encoder_macros.svh =====
// Assertion helpers shared by the RTL files.
// Both sample on clk and stay quiet while rst is high.
`ifndef KEY_MATRIX_DEBOUNCE_ENCODER_MACROS_SVH
`define KEY_MATRIX_DEBOUNCE_ENCODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define KMDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KMDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kmde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kmde_pkg;

  localparam int KMDE_ROWS          = 4;
  localparam int KMDE_COLS          = 4;
  localparam int KMDE_PHYSICAL_KEYS = 8;

  // Configuration register indexes
  localparam logic [2:0] REG_KEY_POSITION_MAP     = 3'd0;
  localparam logic [2:0] REG_SWITCH_KEY_BIT       = 3'd1;
  localparam logic [2:0] REG_CLOCKWISE_KEY_BIT    = 3'd2;
  localparam logic [2:0] REG_CCW_KEY_BIT          = 3'd3;
  localparam logic [2:0] REG_STEPS_PER_DETENT     = 3'd4;
  localparam logic [2:0] REG_DEBOUNCE_WINDOW_US   = 3'd5;
  localparam logic [2:0] REG_ENCODER_REVERSED     = 3'd6;

  // Register reset values
  localparam logic [31:0] RST_KEY_POSITION_MAP   = 32'd1985229328;
  localparam logic [3:0]  RST_SWITCH_KEY_BIT     = 4'd8;
  localparam logic [3:0]  RST_CLOCKWISE_KEY_BIT  = 4'd9;
  localparam logic [3:0]  RST_CCW_KEY_BIT        = 4'd10;
  localparam logic [2:0]  RST_STEPS_PER_DETENT   = 3'd4;
  localparam logic [31:0] RST_DEBOUNCE_WINDOW_US = 32'd5000;

  // Input item kinds
  localparam logic KIND_INIT = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // Both encoder lines toggled at once
  localparam logic [1:0] QUAD_BOTH_CHANGED = 2'b11;

  localparam logic signed [3:0] CLICK_QUEUE_MAX = 4'sd4;
  localparam logic signed [3:0] CLICK_QUEUE_MIN = -4'sd4;

  typedef struct packed {
    logic        kind;
    logic [15:0] row_states;
    logic        encoder_a;
    logic        encoder_b;
    logic        encoder_switch;
    logic [31:0] now_us;
    logic        low_latency_press;
  } kmde_in_t;

  typedef struct packed {
    logic        changed;
    logic [15:0] current_mask;
    logic [15:0] previous_mask;
  } kmde_out_t;

  // Gray-code step for {previous, current} quadrature state
  function automatic logic signed [1:0] kmde_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/key_matrix_debounce_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
//  channel   signals                                   direction
//  in        in_valid, in_ready, in_item               scan samples in
//  out       out_valid, out_ready, out_item            one result per item
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register writes
//
//  One item per cycle sustained while out_ready stays high; path: input register, result register.
//  The whole tick is one pass of logic between the two registers; state updates at once.
//  in_ready and cfg_ready are low during rst; rst is synchronous and restores defaults.
//  cfg_ready is always high out of reset.
//  A stalled out_item holds; one more item waits in the input register, then in_ready drops.
`include "key_matrix_debounce_encoder_macros.svh"

module key_matrix_debounce_encoder #(
  parameter int ROWS          = kmde_pkg::KMDE_ROWS,
  parameter int COLS          = kmde_pkg::KMDE_COLS,
  parameter int PHYSICAL_KEYS = kmde_pkg::KMDE_PHYSICAL_KEYS
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  kmde_pkg::kmde_in_t  in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output kmde_pkg::kmde_out_t out_item,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [2:0]          cfg_index,
  input  wire  [31:0]         cfg_data
);
  import kmde_pkg::*;

  localparam logic [15:0] PhysMask = 16'((1 << PHYSICAL_KEYS) - 1);

  // configuration
  logic [31:0] key_map;
  logic [3:0]  sw_bit;
  logic [3:0]  cw_bit;
  logic [3:0]  ccw_bit;
  logic [2:0]  spd;
  logic [31:0] window_us;
  logic        reversed;

  // block state
  logic [15:0]        reported;
  logic [15:0]        debounced;
  logic [15:0]        last_raw;
  logic [15:0]        prior;
  logic [15:0]        active_pulse;
  logic [31:0]        last_change;
  logic [1:0]         last_quad;
  logic [1:0]         detent_quad;
  logic signed [3:0]  step_acc;
  logic signed [3:0]  pending;

  logic [15:0]        reported_next;
  logic [15:0]        debounced_next;
  logic [15:0]        last_raw_next;
  logic [15:0]        prior_next;
  logic [15:0]        active_pulse_next;
  logic [31:0]        last_change_next;
  logic [1:0]         last_quad_next;
  logic [1:0]         detent_quad_next;
  logic signed [3:0]  step_acc_next;
  logic signed [3:0]  pending_next;
  logic               changed_next;

  // pipeline registers
  logic      in_valid_q;
  kmde_in_t  in_q;
  logic      adv;

  assign adv       = in_valid_q && (!out_valid || out_ready);
  assign in_ready  = !rst && (!in_valid_q || adv);
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
    if (adv) begin
      out_item.changed       <= changed_next;
      out_item.current_mask  <= reported_next;
      out_item.previous_mask <= prior_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_map   <= RST_KEY_POSITION_MAP;
      sw_bit    <= RST_SWITCH_KEY_BIT;
      cw_bit    <= RST_CLOCKWISE_KEY_BIT;
      ccw_bit   <= RST_CCW_KEY_BIT;
      spd       <= RST_STEPS_PER_DETENT;
      window_us <= RST_DEBOUNCE_WINDOW_US;
      reversed  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_POSITION_MAP:   key_map   <= cfg_data;
        REG_SWITCH_KEY_BIT:     sw_bit    <= cfg_data[3:0];
        REG_CLOCKWISE_KEY_BIT:  cw_bit    <= cfg_data[3:0];
        REG_CCW_KEY_BIT:        ccw_bit   <= cfg_data[3:0];
        REG_STEPS_PER_DETENT:   spd       <= cfg_data[2:0];
        REG_DEBOUNCE_WINDOW_US: window_us <= cfg_data;
        REG_ENCODER_REVERSED:   reversed  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // matrix sampling: crossings at or past bit 16 read as released
  logic [COLS-1:0] row_vec [ROWS];

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    for (genvar c = 0; c < COLS; c++) begin : g_col
      localparam int Flat = r * COLS + c;
      if (Flat < 16) begin : g_in
        assign row_vec[r][c] = in_q.row_states[Flat];
      end else begin : g_out
        assign row_vec[r][c] = 1'b0;
      end
    end
  end

  logic        ghost;
  logic [15:0] key_mask;
  logic [15:0] raw_mask;

  always_comb begin
    logic [COLS-1:0] shared;
    ghost = 1'b0;
    for (int r1 = 0; r1 < ROWS; r1++) begin
      for (int r2 = r1 + 1; r2 < ROWS; r2++) begin
        shared = row_vec[r1] & row_vec[r2];
        if ((shared & (shared - COLS'(1))) != '0) begin
          ghost = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [1:0] krow;
    logic [1:0] kcol;
    key_mask = '0;
    for (int k = 0; k < PHYSICAL_KEYS; k++) begin
      krow = key_map[4*k+2 +: 2];
      kcol = key_map[4*k +: 2];
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          if (r < 4 && c < 4 && krow == 2'(r) && kcol == 2'(c) && row_vec[r][c]) begin
            key_mask[k] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    raw_mask = ghost ? (debounced & PhysMask) : key_mask;
    if (in_q.encoder_switch) begin
      raw_mask = raw_mask | (16'b1 << sw_bit);
    end
  end

  // ---------------------------------------------------------------------------
  // quadrature decode
  logic [1:0]        quad;
  logic signed [4:0] acc_sum;
  logic signed [3:0] acc_sat;
  logic signed [4:0] spd_s;
  logic              at_detent;
  logic              click_up;
  logic              click_down;
  logic signed [3:0] enc_acc;
  logic signed [3:0] enc_pending;

  assign quad  = {in_q.encoder_a, in_q.encoder_b};
  assign spd_s = $signed({2'b00, spd});

  always_comb begin
    acc_sum = 5'(step_acc) + 5'(kmde_step({last_quad, quad}));
    if (acc_sum > 5'sd7) begin
      acc_sat = 4'sd7;
    end else if (acc_sum < -5'sd8) begin
      acc_sat = -4'sd8;
    end else begin
      acc_sat = acc_sum[3:0];
    end
    if (spd == 3'd1) begin
      at_detent = 1'b1;
    end else if (spd == 3'd2) begin
      at_detent = (quad == detent_quad) || (quad == (detent_quad ^ QUAD_BOTH_CHANGED));
    end else begin
      at_detent = (quad == detent_quad);
    end
  end

  always_comb begin
    logic cw;
    logic ccw;
    cw      = 1'b0;
    ccw     = 1'b0;
    enc_acc = step_acc;
    if (quad != last_quad) begin
      if ((last_quad ^ quad) == QUAD_BOTH_CHANGED) begin
        enc_acc = '0;
      end else if (5'(acc_sat) >= spd_s) begin
        enc_acc = '0;
        cw      = 1'b1;
      end else if (5'(acc_sat) <= -spd_s) begin
        enc_acc = '0;
        ccw     = 1'b1;
      end else if (at_detent) begin
        enc_acc = '0;
      end else begin
        enc_acc = acc_sat;
      end
    end
    click_up    = reversed ? ccw : cw;
    click_down  = reversed ? cw : ccw;
    enc_pending = pending;
    if (click_up && pending < CLICK_QUEUE_MAX) begin
      enc_pending = pending + 4'sd1;
    end else if (click_down && pending > CLICK_QUEUE_MIN) begin
      enc_pending = pending - 4'sd1;
    end
  end

  // ---------------------------------------------------------------------------
  // report update
  logic [31:0] elapsed;
  logic [15:0] fresh;

  assign elapsed = in_q.now_us - last_change;
  assign fresh   = raw_mask & ~debounced;

  always_comb begin
    reported_next     = reported;
    debounced_next    = debounced;
    last_raw_next     = last_raw;
    prior_next        = prior;
    active_pulse_next = active_pulse;
    last_change_next  = last_change;
    last_quad_next    = quad;
    detent_quad_next  = detent_quad;
    step_acc_next     = enc_acc;
    pending_next      = enc_pending;
    changed_next      = 1'b0;
    if (in_q.kind == KIND_INIT) begin
      detent_quad_next  = quad;
      step_acc_next     = '0;
      pending_next      = '0;
      active_pulse_next = '0;
      debounced_next    = raw_mask;
      reported_next     = raw_mask;
      prior_next        = raw_mask;
      last_raw_next     = raw_mask;
      last_change_next  = in_q.now_us;
    end else if (active_pulse != '0) begin
      // drop the click pulse
      active_pulse_next = '0;
      prior_next        = reported;
      reported_next     = debounced;
      changed_next      = 1'b1;
    end else if (enc_pending > 4'sd0) begin
      pending_next      = enc_pending - 4'sd1;
      active_pulse_next = 16'b1 << cw_bit;
      prior_next        = reported;
      reported_next     = debounced | (16'b1 << cw_bit);
      changed_next      = 1'b1;
    end else if (enc_pending < 4'sd0) begin
      pending_next      = enc_pending + 4'sd1;
      active_pulse_next = 16'b1 << ccw_bit;
      prior_next        = reported;
      reported_next     = debounced | (16'b1 << ccw_bit);
      changed_next      = 1'b1;
    end else if (raw_mask != last_raw) begin
      last_raw_next    = raw_mask;
      last_change_next = in_q.now_us;
      if (in_q.low_latency_press && fresh != '0) begin
        // accept new presses immediately
        debounced_next = debounced | fresh;
        prior_next     = reported;
        reported_next  = debounced | fresh;
        changed_next   = 1'b1;
      end
    end else if (raw_mask != debounced && elapsed >= window_us) begin
      debounced_next = raw_mask;
      prior_next     = reported;
      reported_next  = raw_mask;
      changed_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reported     <= '0;
      debounced    <= '0;
      last_raw     <= '0;
      prior        <= '0;
      active_pulse <= '0;
      last_change  <= '0;
      last_quad    <= '0;
      detent_quad  <= '0;
      step_acc     <= '0;
      pending      <= '0;
    end else if (adv) begin
      reported     <= reported_next;
      debounced    <= debounced_next;
      last_raw     <= last_raw_next;
      prior        <= prior_next;
      active_pulse <= active_pulse_next;
      last_change  <= last_change_next;
      last_quad    <= last_quad_next;
      detent_quad  <= detent_quad_next;
      step_acc     <= step_acc_next;
      pending      <= pending_next;
    end
  end

  // ---------------------------------------------------------------------------
  `KMDE_ASSERT_NOW(a_click_queue_range, 1'b1,
    pending <= CLICK_QUEUE_MAX && pending >= CLICK_QUEUE_MIN, "click queue out of range")
  `KMDE_ASSERT_NOW(a_single_pulse, 1'b1, $onehot0(active_pulse), "more than one pulse bit")
  `KMDE_ASSERT_NOW(a_stall_cause, !in_ready,
    in_valid_q && out_valid && !out_ready, "input stalled without a full pipeline")
  `KMDE_ASSERT_NEXT(a_init_clears, adv && in_q.kind == KIND_INIT,
    pending == 4'sd0 && active_pulse == '0 && !out_item.changed, "init item left encoder state")

endmodule

`default_nettype wire
